>>> sv/acs_pkg.sv
// ----------------------------------------------------------------------------
// acs_pkg
// Shared types, widths and codes for the affinity chunk scheduler.
// ----------------------------------------------------------------------------
package acs_pkg;

  localparam int MAX_WORKERS = 16;
  localparam int INDEX_WIDTH = 16;
  localparam int WID_W       = $clog2(MAX_WORKERS);
  localparam int CNT_W       = 5;
  localparam int FACT_W      = 5;
  localparam int DATA_W      = 16;
  localparam int REG_IDX_W   = 2;
  localparam int DIV_CNT_W   = $clog2(INDEX_WIDTH);

  typedef logic [INDEX_WIDTH-1:0] idx_t;
  typedef logic [WID_W-1:0]       wid_t;
  typedef logic [CNT_W-1:0]       cnt_t;
  typedef logic [FACT_W-1:0]      fact_t;

  // Command codes.
  localparam logic CMD_BEGIN   = 1'b0;
  localparam logic CMD_REQUEST = 1'b1;

  // Configuration register indexes.
  localparam logic [REG_IDX_W-1:0] REG_WORKER_COUNT = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_TOTAL_ITER   = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_TRANSFER     = 2'd2;

  localparam cnt_t  RESET_WORKER_COUNT = 5'd4;
  localparam idx_t  RESET_TOTAL_ITER   = 16'd1024;
  localparam fact_t RESET_TRANSFER     = 5'd4;

  // One entry of the per-worker state memory.
  typedef struct packed {
    idx_t rem;
    idx_t seg_end;
  } entry_t;

  typedef struct packed {
    logic   en;
    wid_t   addr;
    entry_t data;
  } mem_wr_t;

  typedef struct packed {
    logic  go;
    idx_t  dividend;
    fact_t divisor;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BEGIN_DIV,
    ST_BEGIN_MUL,
    ST_BEGIN_WR,
    ST_REQ_READ,
    ST_SCAN,
    ST_SCAN_LAST,
    ST_STEAL_CHK,
    ST_STEAL_DIV,
    ST_STEAL_WR,
    ST_GRANT,
    ST_GRANT_DIV,
    ST_GRANT_WR
  } state_t;

endpackage

>>> sv/acs_mem.sv
// ----------------------------------------------------------------------------
// acs_mem
// Per-worker state memory: remaining count and segment end for each worker,
// one write and one registered read per cycle. Entries never written read
// as zero.
// ----------------------------------------------------------------------------
module acs_mem (
  input  logic             clk,
  input  logic             rst,
  input  acs_pkg::mem_wr_t wr,
  input  logic             rd_en,
  input  acs_pkg::wid_t    rd_addr,
  output acs_pkg::entry_t  rd_data
);

  logic [acs_pkg::MAX_WORKERS-1:0] valid;
  acs_pkg::entry_t                 mem [acs_pkg::MAX_WORKERS];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr.en) begin
      valid[wr.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rd_data <= valid[rd_addr] ? mem[rd_addr] : '0;
    end
  end

endmodule

>>> sv/acs_div.sv
// ----------------------------------------------------------------------------
// acs_div
// Radix-2 restoring divider: index-wide dividend by a small nonzero divisor,
// one quotient bit per cycle.
// ----------------------------------------------------------------------------
module acs_div (
  input  logic               clk,
  input  logic               rst,
  input  acs_pkg::div_req_t  req,
  output acs_pkg::div_stat_t stat,
  output acs_pkg::idx_t      quotient
);

  logic                          running;
  logic                          done;
  logic [acs_pkg::DIV_CNT_W-1:0] cnt;
  acs_pkg::idx_t                 quo;
  acs_pkg::fact_t                part;
  acs_pkg::fact_t                dvs;
  logic [acs_pkg::FACT_W:0]      trial;
  logic [acs_pkg::FACT_W:0]      diff;
  logic                          ge;

  assign trial = {part, quo[acs_pkg::INDEX_WIDTH-1]};
  assign ge    = trial >= {1'b0, dvs};
  assign diff  = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (req.go) begin
        running <= 1'b1;
        cnt     <= '0;
      end else if (running) begin
        cnt <= cnt + 1'b1;
        if (cnt == acs_pkg::DIV_CNT_W'(acs_pkg::INDEX_WIDTH - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  // The partial remainder always stays below the divisor, so it fits the
  // divisor's width after each step.
  always_ff @(posedge clk) begin
    if (req.go) begin
      quo  <= req.dividend;
      part <= '0;
      dvs  <= req.divisor;
    end else if (running) begin
      part <= ge ? diff[acs_pkg::FACT_W-1:0] : trial[acs_pkg::FACT_W-1:0];
      quo  <= {quo[acs_pkg::INDEX_WIDTH-2:0], ge};
    end
  end

  assign stat.busy = running;
  assign stat.done = done;
  assign quotient  = quo;

endmodule

>>> sv/affinity_chunk_scheduler_top.sv
// ----------------------------------------------------------------------------
// affinity_chunk_scheduler_top
// Affinity scheduling of loop iteration chunks across up to sixteen workers.
// ----------------------------------------------------------------------------
// Usage:
//   A command transaction is taken when start is high and busy is low. A
//   begin command sets up the worker's own segment; a request grants the
//   next chunk, stealing from the most-loaded worker when the segment is
//   empty. Every command yields one result, shown for one cycle with done
//   high; the receiver cannot stall it, and it must take it then.
//   A worker id out of range is answered with finished and no chunk. A
//   begin divides the total among the workers; a request served from the
//   worker's own segment divides unless fewer iterations remain than
//   workers. A request that has to steal scans the state memory first and
//   then divides when it steals. The radix-2 divider is shared by all
//   divides, and the scan reads one entry of the state memory per cycle.
//   One command is in flight at a time. Configuration writes (cfg_write,
//   cfg_index, cfg_data) take effect at once; the user must make them
//   only while busy is low, which the block itself does not enforce.
//   Reset restores the register defaults and makes every worker's
//   remaining count and segment end read as zero; no clearing pass is
//   needed.
// ----------------------------------------------------------------------------
module affinity_chunk_scheduler_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic                            command,
  input  logic [acs_pkg::WID_W-1:0]       worker_id,
  input  logic                            cfg_write,
  input  logic [acs_pkg::REG_IDX_W-1:0]   cfg_index,
  input  logic [acs_pkg::DATA_W-1:0]      cfg_data,
  output logic                            done,
  output logic [acs_pkg::INDEX_WIDTH-1:0] chunk_start,
  output logic [acs_pkg::INDEX_WIDTH-1:0] chunk_length,
  output logic                            finished,
  output logic                            stolen,
  output logic [acs_pkg::WID_W-1:0]       victim_id
);

  acs_pkg::state_t    state, state_next;
  acs_pkg::cnt_t      worker_count;
  acs_pkg::idx_t      total_iterations;
  acs_pkg::fact_t     transfer_factor;
  acs_pkg::cnt_t      p;
  acs_pkg::cnt_t      p_m1;
  acs_pkg::fact_t     tf;
  logic               accept;
  logic               w_ok;

  acs_pkg::wid_t      cur_w, cur_w_next;
  acs_pkg::idx_t      cur_rem, cur_rem_next;
  acs_pkg::idx_t      cur_end, cur_end_next;
  acs_pkg::idx_t      cur_len, cur_len_next;
  acs_pkg::idx_t      seg, seg_next;
  acs_pkg::idx_t      prod_a, prod_a_next;
  acs_pkg::idx_t      prod_b, prod_b_next;
  acs_pkg::idx_t      best, best_next;
  acs_pkg::idx_t      best_end, best_end_next;
  acs_pkg::wid_t      victim, victim_next;
  logic               found, found_next;
  logic               steal, steal_next;
  acs_pkg::wid_t      scan_ptr, scan_ptr_next;
  logic               cmp_vld, cmp_vld_next;
  acs_pkg::wid_t      cmp_idx, cmp_idx_next;

  logic [acs_pkg::INDEX_WIDTH+acs_pkg::CNT_W-1:0] mul_a;
  logic [acs_pkg::INDEX_WIDTH+acs_pkg::WID_W-1:0] mul_b;
  acs_pkg::idx_t      itr;

  acs_pkg::mem_wr_t   mem_wr;
  logic               rd_en;
  acs_pkg::wid_t      rd_addr;
  acs_pkg::entry_t    rd_data;
  acs_pkg::div_req_t  div_req;
  acs_pkg::div_stat_t div_stat;
  acs_pkg::idx_t      quotient;

  logic               res_load;
  acs_pkg::idx_t      res_start;
  acs_pkg::idx_t      res_len;
  logic               res_fin;
  logic               res_stolen;
  acs_pkg::wid_t      res_victim;

  acs_mem u_mem (
    .clk     (clk),
    .rst     (rst),
    .wr      (mem_wr),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  acs_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .stat     (div_stat),
    .quotient (quotient)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      worker_count     <= acs_pkg::RESET_WORKER_COUNT;
      total_iterations <= acs_pkg::RESET_TOTAL_ITER;
      transfer_factor  <= acs_pkg::RESET_TRANSFER;
    end else if (cfg_write) begin
      case (cfg_index)
        acs_pkg::REG_WORKER_COUNT: worker_count     <= cfg_data[acs_pkg::CNT_W-1:0];
        acs_pkg::REG_TOTAL_ITER:   total_iterations <= cfg_data[acs_pkg::INDEX_WIDTH-1:0];
        acs_pkg::REG_TRANSFER:     transfer_factor  <= cfg_data[acs_pkg::FACT_W-1:0];
        default: ;
      endcase
    end
  end

  // A worker count of zero acts as one, and counts above the table size
  // are clamped to it; a transfer factor of zero acts as one.
  always_comb begin
    if (worker_count == '0) begin
      p = acs_pkg::CNT_W'(1);
    end else if (worker_count > acs_pkg::CNT_W'(acs_pkg::MAX_WORKERS)) begin
      p = acs_pkg::CNT_W'(acs_pkg::MAX_WORKERS);
    end else begin
      p = worker_count;
    end
    tf = (transfer_factor == '0) ? acs_pkg::FACT_W'(1) : transfer_factor;
  end

  assign p_m1   = p - 1'b1;
  assign busy   = (state != acs_pkg::ST_IDLE);
  assign accept = start && !busy;
  assign w_ok   = {1'b0, worker_id} < p;
  assign mul_a  = seg * p_m1;
  assign mul_b  = seg * cur_w;
  assign itr    = ({1'b0, cur_w} == p_m1) ? (total_iterations - prod_a) : seg;

  always_comb begin
    state_next    = state;
    cur_w_next    = cur_w;
    cur_rem_next  = cur_rem;
    cur_end_next  = cur_end;
    cur_len_next  = cur_len;
    seg_next      = seg;
    prod_a_next   = prod_a;
    prod_b_next   = prod_b;
    best_next     = best;
    best_end_next = best_end;
    victim_next   = victim;
    found_next    = found;
    steal_next    = steal;
    scan_ptr_next = scan_ptr;
    cmp_vld_next  = 1'b0;
    cmp_idx_next  = cmp_idx;

    mem_wr        = '0;
    rd_en         = 1'b0;
    rd_addr       = worker_id;
    div_req       = '0;

    res_load      = 1'b0;
    res_start     = '0;
    res_len       = '0;
    res_fin       = 1'b0;
    res_stolen    = 1'b0;
    res_victim    = '0;

    // A scan result from the previous read is compared while scanning.
    if ((state == acs_pkg::ST_SCAN || state == acs_pkg::ST_SCAN_LAST) &&
        cmp_vld && (rd_data.rem > best)) begin
      best_next     = rd_data.rem;
      best_end_next = rd_data.seg_end;
      victim_next   = cmp_idx;
      found_next    = 1'b1;
    end

    case (state)
      acs_pkg::ST_IDLE: begin
        if (accept) begin
          cur_w_next = worker_id;
          steal_next = 1'b0;
          if (!w_ok) begin
            res_load = 1'b1;
            res_fin  = 1'b1;
          end else if (command == acs_pkg::CMD_BEGIN) begin
            div_req.go       = 1'b1;
            div_req.dividend = total_iterations;
            div_req.divisor  = p;
            state_next       = acs_pkg::ST_BEGIN_DIV;
          end else begin
            rd_en      = 1'b1;
            state_next = acs_pkg::ST_REQ_READ;
          end
        end
      end

      acs_pkg::ST_BEGIN_DIV: begin
        if (div_stat.done) begin
          seg_next   = quotient;
          state_next = acs_pkg::ST_BEGIN_MUL;
        end
      end

      acs_pkg::ST_BEGIN_MUL: begin
        prod_a_next = mul_a[acs_pkg::INDEX_WIDTH-1:0];
        prod_b_next = mul_b[acs_pkg::INDEX_WIDTH-1:0];
        state_next  = acs_pkg::ST_BEGIN_WR;
      end

      acs_pkg::ST_BEGIN_WR: begin
        mem_wr.en           = 1'b1;
        mem_wr.addr         = cur_w;
        mem_wr.data.rem     = itr;
        mem_wr.data.seg_end = prod_b + itr;
        res_load            = 1'b1;
        res_start           = prod_b;
        state_next          = acs_pkg::ST_IDLE;
      end

      acs_pkg::ST_REQ_READ: begin
        if (rd_data.rem != '0) begin
          cur_rem_next = rd_data.rem;
          cur_end_next = rd_data.seg_end;
          state_next   = acs_pkg::ST_GRANT;
        end else begin
          scan_ptr_next = '0;
          best_next     = {{(acs_pkg::INDEX_WIDTH-acs_pkg::FACT_W){1'b0}}, tf};
          found_next    = 1'b0;
          victim_next   = cur_w;
          state_next    = acs_pkg::ST_SCAN;
        end
      end

      acs_pkg::ST_SCAN: begin
        rd_en        = 1'b1;
        rd_addr      = scan_ptr;
        cmp_vld_next = 1'b1;
        cmp_idx_next = scan_ptr;
        if ({1'b0, scan_ptr} == p_m1) begin
          state_next = acs_pkg::ST_SCAN_LAST;
        end else begin
          scan_ptr_next = scan_ptr + 1'b1;
        end
      end

      acs_pkg::ST_SCAN_LAST: begin
        state_next = acs_pkg::ST_STEAL_CHK;
      end

      acs_pkg::ST_STEAL_CHK: begin
        if (!found || victim == cur_w) begin
          res_load   = 1'b1;
          res_fin    = 1'b1;
          state_next = acs_pkg::ST_IDLE;
        end else begin
          div_req.go       = 1'b1;
          div_req.dividend = best;
          div_req.divisor  = tf;
          state_next       = acs_pkg::ST_STEAL_DIV;
        end
      end

      acs_pkg::ST_STEAL_DIV: begin
        if (div_stat.done) begin
          state_next = acs_pkg::ST_STEAL_WR;
        end
      end

      // The thief takes the top of the victim's segment.
      acs_pkg::ST_STEAL_WR: begin
        mem_wr.en           = 1'b1;
        mem_wr.addr         = victim;
        mem_wr.data.rem     = best - quotient;
        mem_wr.data.seg_end = best_end - quotient;
        cur_rem_next        = quotient;
        cur_end_next        = best_end;
        steal_next          = 1'b1;
        state_next          = acs_pkg::ST_GRANT;
      end

      acs_pkg::ST_GRANT: begin
        if (cur_rem < {{(acs_pkg::INDEX_WIDTH-acs_pkg::CNT_W){1'b0}}, p}) begin
          cur_len_next = acs_pkg::INDEX_WIDTH'(1);
          state_next   = acs_pkg::ST_GRANT_WR;
        end else begin
          div_req.go       = 1'b1;
          div_req.dividend = cur_rem;
          div_req.divisor  = p;
          state_next       = acs_pkg::ST_GRANT_DIV;
        end
      end

      acs_pkg::ST_GRANT_DIV: begin
        if (div_stat.done) begin
          cur_len_next = quotient;
          state_next   = acs_pkg::ST_GRANT_WR;
        end
      end

      acs_pkg::ST_GRANT_WR: begin
        mem_wr.en           = 1'b1;
        mem_wr.addr         = cur_w;
        mem_wr.data.rem     = cur_rem - cur_len;
        mem_wr.data.seg_end = cur_end;
        res_load            = 1'b1;
        res_start           = cur_end - cur_rem;
        res_len             = cur_len;
        res_stolen          = steal;
        res_victim          = steal ? victim : '0;
        state_next          = acs_pkg::ST_IDLE;
      end

      default: begin
        state_next = acs_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= acs_pkg::ST_IDLE;
      cmp_vld <= 1'b0;
      done    <= 1'b0;
    end else begin
      state   <= state_next;
      cmp_vld <= cmp_vld_next;
      done    <= res_load;
    end
  end

  always_ff @(posedge clk) begin
    cur_w    <= cur_w_next;
    cur_rem  <= cur_rem_next;
    cur_end  <= cur_end_next;
    cur_len  <= cur_len_next;
    seg      <= seg_next;
    prod_a   <= prod_a_next;
    prod_b   <= prod_b_next;
    best     <= best_next;
    best_end <= best_end_next;
    victim   <= victim_next;
    found    <= found_next;
    steal    <= steal_next;
    scan_ptr <= scan_ptr_next;
    cmp_idx  <= cmp_idx_next;
    if (res_load) begin
      chunk_start  <= res_start;
      chunk_length <= res_len;
      finished     <= res_fin;
      stolen       <= res_stolen;
      victim_id    <= res_victim;
    end
  end

`ifndef ASSERT_OFF
  // The sequencer never reads an entry in the cycle it writes it.
  assert property (@(posedge clk) disable iff (rst)
    !(mem_wr.en && rd_en && (mem_wr.addr == rd_addr)))
    else $error("state memory read and write hit the same entry");

  assert property (@(posedge clk) disable iff (rst)
    div_req.go |-> !div_stat.busy)
    else $error("divider started while still running");

  assert property (@(posedge clk) disable iff (rst)
    (done && stolen) |-> ((victim_id != cur_w) && (chunk_length != '0)))
    else $error("steal reported against the requesting worker or empty");

  assert property (@(posedge clk) disable iff (rst)
    (done && finished) |-> ((chunk_length == '0) && !stolen))
    else $error("finished result carries a chunk");
`endif

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the affinity chunk scheduler against a cycle-free predictor.
// Directed commands cover out-of-range workers, empty segments, stealing and
// the clamped register values. Random phases then begin the workers and
// drain their segments under changing settings. Every result is checked
// field by field, in order.
// ----------------------------------------------------------------------------
module testbench;

  // Index 3 has no register behind it; writes to it must be ignored.
  localparam logic [acs_pkg::REG_IDX_W-1:0] REG_SPARE = 2'd3;

  localparam int PHASE_ITEMS  = 95;
  localparam int RANDOM_PHASES = 12;

  typedef struct {
    logic          cmd;
    acs_pkg::wid_t wid;
  } sched_cmd_t;

  typedef struct {
    acs_pkg::idx_t start_idx;
    acs_pkg::idx_t length;
    logic          fin;
    logic          stl;
    acs_pkg::wid_t vic;
  } grant_t;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            start = 1'b0;
  logic                            busy;
  logic                            command = 1'b0;
  logic [acs_pkg::WID_W-1:0]       worker_id = '0;
  logic                            cfg_write = 1'b0;
  logic [acs_pkg::REG_IDX_W-1:0]   cfg_index = '0;
  logic [acs_pkg::DATA_W-1:0]      cfg_data = '0;
  logic                            done;
  logic [acs_pkg::INDEX_WIDTH-1:0] chunk_start;
  logic [acs_pkg::INDEX_WIDTH-1:0] chunk_length;
  logic                            finished;
  logic                            stolen;
  logic [acs_pkg::WID_W-1:0]       victim_id;

  // Predictor copy of the registers and the per-worker state.
  acs_pkg::cnt_t  cfg_workers  = acs_pkg::RESET_WORKER_COUNT;
  acs_pkg::idx_t  cfg_total    = acs_pkg::RESET_TOTAL_ITER;
  acs_pkg::fact_t cfg_transfer = acs_pkg::RESET_TRANSFER;
  acs_pkg::idx_t  left_count [acs_pkg::MAX_WORKERS];
  acs_pkg::idx_t  top_index  [acs_pkg::MAX_WORKERS];

  sched_cmd_t cmd_queue[$];
  grant_t     expected_grants[$];

  bit idle_on = 1'b0;
  int idle_left = 0;
  int n_accepted = 0;
  int n_results = 0;
  int n_chunks = 0;
  int n_steals = 0;
  int n_finished = 0;
  int n_cfg_writes = 0;
  int n_mismatches = 0;

  affinity_chunk_scheduler_top i_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .command      (command),
    .worker_id    (worker_id),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .done         (done),
    .chunk_start  (chunk_start),
    .chunk_length (chunk_length),
    .finished     (finished),
    .stolen       (stolen),
    .victim_id    (victim_id)
  );

  always #2 clk = ~clk;

  initial begin
    for (int i = 0; i < acs_pkg::MAX_WORKERS; i++) begin
      left_count[i] = '0;
      top_index[i]  = '0;
    end
  end

  // Works out the grant for one command and updates the scheduler state.
  function automatic grant_t schedule_cmd(logic cmd, acs_pkg::wid_t w);
    grant_t      g;
    int unsigned p, tf, seg, itr, best, take, r, len;
    int          victim, t;
    bit          found;
    g = '{default: '0};
    p = (cfg_workers == 0) ? 1 :
        ((cfg_workers > acs_pkg::MAX_WORKERS) ? acs_pkg::MAX_WORKERS : cfg_workers);
    tf = (cfg_transfer == 0) ? 1 : cfg_transfer;
    if (w >= p) begin
      g.fin = 1'b1;
      return g;
    end
    if (cmd == acs_pkg::CMD_BEGIN) begin
      seg = cfg_total / p;
      itr = (w == p - 1) ? (cfg_total - seg * (p - 1)) : seg;
      left_count[w] = acs_pkg::idx_t'(itr);
      top_index[w]  = acs_pkg::idx_t'(w * seg + itr);
      g.start_idx   = acs_pkg::idx_t'(w * seg);
      return g;
    end
    if (left_count[w] == 0) begin
      best = tf;
      victim = w;
      found = 1'b0;
      for (t = 0; t < p; t++) begin
        if (left_count[t] > best) begin
          best = left_count[t];
          victim = t;
          found = 1'b1;
        end
      end
      if (!found || victim == w) begin
        g.fin = 1'b1;
        return g;
      end
      // The thief takes the top part of the victim's segment.
      take = left_count[victim] / tf;
      left_count[victim] = acs_pkg::idx_t'(left_count[victim] - take);
      top_index[w]       = top_index[victim];
      top_index[victim]  = acs_pkg::idx_t'(top_index[victim] - take);
      left_count[w]      = acs_pkg::idx_t'(take);
      g.stl = 1'b1;
      g.vic = acs_pkg::wid_t'(victim);
    end
    r = left_count[w];
    len = (r < p) ? 1 : r / p;
    g.start_idx   = acs_pkg::idx_t'(top_index[w] - r);
    g.length      = acs_pkg::idx_t'(len);
    left_count[w] = acs_pkg::idx_t'(r - len);
    return g;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
    n_mismatches++;
    $display("[%0t] ERROR %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
  endtask

  function automatic void push_cmd(logic c, int w);
    sched_cmd_t it;
    it.cmd = c;
    it.wid = acs_pkg::wid_t'(w);
    cmd_queue.push_back(it);
  endfunction

  task automatic write_reg(logic [acs_pkg::REG_IDX_W-1:0] idx,
                           logic [acs_pkg::DATA_W-1:0] data);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      acs_pkg::REG_WORKER_COUNT: cfg_workers  = acs_pkg::cnt_t'(data);
      acs_pkg::REG_TOTAL_ITER:   cfg_total    = acs_pkg::idx_t'(data);
      acs_pkg::REG_TRANSFER:     cfg_transfer = acs_pkg::fact_t'(data);
      default: ;
    endcase
    n_cfg_writes++;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic wait_quiet();
    while (cmd_queue.size() != 0 || start || expected_grants.size() != 0 || busy)
      @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Driver: start stays high until the block takes the transaction.
  always @(posedge clk) begin : drive_proc
    logic       next_start;
    sched_cmd_t nxt;
    if (rst) begin
      start <= 1'b0;
      idle_left <= 0;
    end else begin
      next_start = start;
      if (start && !busy) begin
        expected_grants.push_back(schedule_cmd(command, worker_id));
        n_accepted++;
        next_start = 1'b0;
      end
      if (!next_start) begin
        if (idle_left > 0) begin
          idle_left <= idle_left - 1;
        end else if (cmd_queue.size() > 0) begin
          if (idle_on && $urandom_range(0, 5) == 0) begin
            idle_left <= int'($urandom_range(0, 18));
          end else begin
            nxt = cmd_queue.pop_front();
            command <= nxt.cmd;
            worker_id <= nxt.wid;
            next_start = 1'b1;
          end
        end
      end
      start <= next_start;
    end
  end

  always @(posedge clk) begin : check_proc
    grant_t want;
    if (!rst && done === 1'b1) begin
      n_results++;
      if (expected_grants.size() == 0) begin
        report_mismatch("result with no command outstanding", '0, 32'(chunk_start));
      end else begin
        want = expected_grants.pop_front();
        if (chunk_start !== want.start_idx)
          report_mismatch("chunk_start", 32'(want.start_idx), 32'(chunk_start));
        if (chunk_length !== want.length)
          report_mismatch("chunk_length", 32'(want.length), 32'(chunk_length));
        if (finished !== want.fin)
          report_mismatch("finished", 32'(want.fin), 32'(finished));
        if (stolen !== want.stl)
          report_mismatch("stolen", 32'(want.stl), 32'(stolen));
        if (victim_id !== want.vic)
          report_mismatch("victim_id", 32'(want.vic), 32'(victim_id));
        if (want.stl) n_steals++;
        if (want.fin) n_finished++;
        else if (want.length != 0) n_chunks++;
      end
    end
  end

  initial begin : stimulus
    int          ph, w, r, eff, val;
    bit          upward;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    idle_on = 1'b1;

    // Reset settings: four workers, 1024 iterations, factor 4.
    push_cmd(acs_pkg::CMD_REQUEST, 0);   // nothing begun yet, nothing to steal
    push_cmd(acs_pkg::CMD_BEGIN, 9);     // worker beyond the worker count
    push_cmd(acs_pkg::CMD_BEGIN, 0);
    push_cmd(acs_pkg::CMD_BEGIN, 1);
    push_cmd(acs_pkg::CMD_BEGIN, 2);
    push_cmd(acs_pkg::CMD_REQUEST, 3);   // empty segment, steals from worker 0
    push_cmd(acs_pkg::CMD_REQUEST, 0);
    push_cmd(acs_pkg::CMD_REQUEST, 1);
    push_cmd(acs_pkg::CMD_REQUEST, 3);
    push_cmd(acs_pkg::CMD_BEGIN, 3);     // last worker takes the remainder
    push_cmd(acs_pkg::CMD_REQUEST, 3);
    push_cmd(acs_pkg::CMD_REQUEST, 2);
    wait_quiet();

    // A worker count of zero behaves as one worker.
    write_reg(acs_pkg::REG_WORKER_COUNT, 16'h0000);
    write_reg(acs_pkg::REG_TOTAL_ITER, 16'hFFFF);
    push_cmd(acs_pkg::CMD_BEGIN, 0);
    push_cmd(acs_pkg::CMD_REQUEST, 0);
    push_cmd(acs_pkg::CMD_REQUEST, 0);
    push_cmd(acs_pkg::CMD_REQUEST, 1);
    wait_quiet();

    // Oversized worker count, empty range and a zero factor.
    write_reg(acs_pkg::REG_WORKER_COUNT, 16'h001F);
    write_reg(acs_pkg::REG_TOTAL_ITER, 16'h0000);
    write_reg(acs_pkg::REG_TRANSFER, 16'h0000);
    push_cmd(acs_pkg::CMD_BEGIN, 15);
    push_cmd(acs_pkg::CMD_REQUEST, 15);
    push_cmd(acs_pkg::CMD_REQUEST, 15);
    push_cmd(acs_pkg::CMD_REQUEST, 5);
    push_cmd(acs_pkg::CMD_BEGIN, 3);
    wait_quiet();

    write_reg(acs_pkg::REG_WORKER_COUNT, 16'h0010);
    write_reg(acs_pkg::REG_TOTAL_ITER, 16'hFFFF);
    write_reg(acs_pkg::REG_TRANSFER, 16'hFFFF);
    write_reg(REG_SPARE, 16'hA5A5);
    push_cmd(acs_pkg::CMD_BEGIN, 0);
    push_cmd(acs_pkg::CMD_REQUEST, 0);
    push_cmd(acs_pkg::CMD_REQUEST, 0);
    push_cmd(acs_pkg::CMD_REQUEST, 15);
    wait_quiet();

    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      // No idling in the last phases, nor in one phase in the middle.
      idle_on = (ph < RANDOM_PHASES - 2) && (ph != 5);

      if (ph == 0) val = 16;
      else if (ph == RANDOM_PHASES - 1) val = 1;
      else if ($urandom_range(0, 9) == 0) val = $urandom_range(0, 31);
      else val = $urandom_range(1, 16);
      if (ph == 0 || ph == RANDOM_PHASES - 1 || $urandom_range(0, 4) != 0)
        write_reg(acs_pkg::REG_WORKER_COUNT, {11'($urandom), 5'(val)});

      if (ph == 0) val = 1;
      else if (ph == RANDOM_PHASES - 1) val = 16;
      else if ($urandom_range(0, 9) == 0) val = $urandom_range(0, 31);
      else val = $urandom_range(1, 16);
      if (ph == 0 || ph == RANDOM_PHASES - 1 || $urandom_range(0, 4) != 0)
        write_reg(acs_pkg::REG_TRANSFER, {11'($urandom), 5'(val)});

      r = $urandom_range(0, 9);
      if (ph == RANDOM_PHASES - 1) val = $urandom_range(1, 40);
      else if (r == 0) val = 16'hFFFF;
      else if (r < 5) val = $urandom_range(1, 300);
      else val = $urandom_range(0, 65535);
      if (ph == 0 || ph == RANDOM_PHASES - 1 || $urandom_range(0, 4) != 0)
        write_reg(acs_pkg::REG_TOTAL_ITER, 16'(val));

      if ($urandom_range(0, 9) == 0)
        write_reg(REG_SPARE, 16'($urandom));

      eff = (cfg_workers == 0) ? 1 :
            ((cfg_workers > acs_pkg::MAX_WORKERS) ? acs_pkg::MAX_WORKERS : cfg_workers);

      // Most workers begin their own segment; the rest must steal.
      upward = $urandom_range(0, 1);
      for (w = 0; w < eff; w++) begin
        if ($urandom_range(0, 9) != 0)
          push_cmd(acs_pkg::CMD_BEGIN, upward ? w : eff - 1 - w);
      end
      while (cmd_queue.size() < PHASE_ITEMS) begin
        r = $urandom_range(0, 19);
        if (r < 2) push_cmd(1'($urandom_range(0, 1)), $urandom_range(0, 15));
        else if (r == 2) push_cmd(acs_pkg::CMD_BEGIN, $urandom_range(0, eff - 1));
        else push_cmd(acs_pkg::CMD_REQUEST, $urandom_range(0, eff - 1));
      end
      wait_quiet();
    end

    repeat (60) @(posedge clk);
    $display("Covered %0d commands under %0d register writes and %0d settings.",
             n_accepted, n_cfg_writes, RANDOM_PHASES + 4);
    $display("Results: %0d chunks granted, %0d by stealing, %0d finished answers.",
             n_chunks, n_steals, n_finished);
    if (n_mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d field mismatches found.", n_mismatches);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin : watchdog
    #3_000_000;
    $display("Timed out with %0d commands queued and %0d results outstanding.",
             cmd_queue.size(), expected_grants.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

>>> sim.f
sv/acs_pkg.sv
sv/acs_mem.sv
sv/acs_div.sv
sv/affinity_chunk_scheduler_top.sv
dv/testbench.sv
